FILE: rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared widths, angle constants, arctangent table and the side-band record
// that travels with each vector through the rotation pipeline.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // field widths of the transactions
  localparam int VEC_W   = 32;
  localparam int ANG_W   = 20;
  localparam int AXIS_W  = 18;

  // internal widths: folded angle / cordic z, cordic x and y, rounded k*k entry
  localparam int ANG_Q_W = 34;
  localparam int CW      = 33;
  localparam int KK_W    = 28;

  localparam int STEPS   = 24;

  // angle constants, radians in q30
  localparam logic signed [ANG_Q_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_Q_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_Q_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [CW-1:0]      GAIN_Q30    = 33'sd652032874;

  // arctangent of 2^-i in q30
  localparam logic signed [ANG_Q_W-1:0] ATAN_Q30 [STEPS] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  // per-item data carried alongside the angle work
  // kk_off[n] is the product of the two axis components other than n
  typedef struct packed {
    logic [2:0][VEC_W-1:0]  vec;
    logic [2:0][AXIS_W-1:0] axis;
    logic [2:0][KK_W-1:0]   kk_diag;
    logic [2:0][KK_W-1:0]   kk_off;
  } side_t;

endpackage

FILE: rtl/aavr_if.sv
// ----------------------------------------------------------------------------
// aavr_in_if / aavr_out_if
// Valid/ready channels for the vector, angle and axis in, and the rotated
// vector out.
// ----------------------------------------------------------------------------
interface aavr_in_if;
  import aavr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VEC_W-1:0]  vec_x;
  logic signed [VEC_W-1:0]  vec_y;
  logic signed [VEC_W-1:0]  vec_z;
  logic signed [ANG_W-1:0]  turn_angle;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;

  modport source (
    output valid, vec_x, vec_y, vec_z, turn_angle, axis_x, axis_y, axis_z,
    input  ready
  );
  modport sink (
    input  valid, vec_x, vec_y, vec_z, turn_angle, axis_x, axis_y, axis_z,
    output ready
  );
endinterface

interface aavr_out_if;
  import aavr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] rot_x;
  logic signed [VEC_W-1:0] rot_y;
  logic signed [VEC_W-1:0] rot_z;

  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

FILE: rtl/aavr_fold.sv
// ----------------------------------------------------------------------------
// aavr_fold
// Three stages: angle scaling and clamp with axis clamp, wrap into +-pi with
// the axis products, mirror into +-pi/2 with rounding of the k*k entries.
// ----------------------------------------------------------------------------
module aavr_fold #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [aavr_pkg::VEC_W-1:0]  vec_x_i,
  input  logic signed [aavr_pkg::VEC_W-1:0]  vec_y_i,
  input  logic signed [aavr_pkg::VEC_W-1:0]  vec_z_i,
  input  logic signed [aavr_pkg::ANG_W-1:0]  turn_angle_i,
  input  logic signed [aavr_pkg::AXIS_W-1:0] axis_x_i,
  input  logic signed [aavr_pkg::AXIS_W-1:0] axis_y_i,
  input  logic signed [aavr_pkg::AXIS_W-1:0] axis_z_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [aavr_pkg::ANG_Q_W-1:0] angle_o,
  output logic                               flip_o,
  output aavr_pkg::side_t                    side_o
);
  import aavr_pkg::*;

  localparam int N     = 3;
  localparam int SH    = 30 - FRAC_BITS;
  localparam int TA_W  = (ANG_W + SH + 1 > ANG_Q_W + 1) ? ANG_W + SH + 1 : ANG_Q_W + 1;
  localparam int SQ_W  = 2 * AXIS_W;
  localparam int KKF_W = SQ_W + 2;

  logic [N-1:0] v_q;
  logic [N:0]   en;

  // stage enables: a stage moves when it is empty or its successor moves
  always_comb begin
    en[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: scale angle to q30 and clamp to +-2pi, clamp axis to +-1
  logic signed [TA_W-1:0]    ta;
  logic signed [ANG_Q_W-1:0] t0_d, t0_q;
  logic signed [AXIS_W-1:0]  ax_in [3];
  logic signed [AXIS_W-1:0]  ax0_d [3];
  logic signed [AXIS_W-1:0]  ax0_q [3];
  logic [2:0][VEC_W-1:0]     vec0_q;

  always_comb begin
    ta = TA_W'(turn_angle_i) <<< SH;
    if (ta > TA_W'(TWO_PI_Q30)) begin
      t0_d = TWO_PI_Q30;
    end else if (ta < -TA_W'(TWO_PI_Q30)) begin
      t0_d = -TWO_PI_Q30;
    end else begin
      t0_d = ANG_Q_W'(ta);
    end
    ax_in[0] = axis_x_i;
    ax_in[1] = axis_y_i;
    ax_in[2] = axis_z_i;
    for (int n = 0; n < 3; n++) begin
      if (int'(ax_in[n]) > (1 << FRAC_BITS)) begin
        ax0_d[n] = AXIS_W'(1 << FRAC_BITS);
      end else if (int'(ax_in[n]) < -(1 << FRAC_BITS)) begin
        ax0_d[n] = AXIS_W'(-(1 << FRAC_BITS));
      end else begin
        ax0_d[n] = ax_in[n];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t0_q   <= t0_d;
      ax0_q  <= ax0_d;
      vec0_q <= {vec_z_i, vec_y_i, vec_x_i};
    end
  end

  // stage 1: wrap into +-pi, form the exact k*k entries
  logic signed [ANG_Q_W:0]   t1_w;
  logic signed [ANG_Q_W-1:0] t1_q;
  logic signed [SQ_W-1:0]    sq [3];
  logic signed [KKF_W-1:0]   kd1_d [3];
  logic signed [KKF_W-1:0]   ko1_d [3];
  logic signed [KKF_W-1:0]   kd1_q [3];
  logic signed [KKF_W-1:0]   ko1_q [3];
  logic signed [AXIS_W-1:0]  ax1_q [3];
  logic [2:0][VEC_W-1:0]     vec1_q;

  always_comb begin
    if (t0_q > PI_Q30) begin
      t1_w = (ANG_Q_W+1)'(t0_q) - (ANG_Q_W+1)'(TWO_PI_Q30);
    end else if (t0_q < -PI_Q30) begin
      t1_w = (ANG_Q_W+1)'(t0_q) + (ANG_Q_W+1)'(TWO_PI_Q30);
    end else begin
      t1_w = (ANG_Q_W+1)'(t0_q);
    end
    for (int n = 0; n < 3; n++) begin
      sq[n] = SQ_W'(ax0_q[n]) * SQ_W'(ax0_q[n]);
    end
    kd1_d[0] = -(KKF_W'(sq[1]) + KKF_W'(sq[2]));
    kd1_d[1] = -(KKF_W'(sq[0]) + KKF_W'(sq[2]));
    kd1_d[2] = -(KKF_W'(sq[0]) + KKF_W'(sq[1]));
    ko1_d[0] = KKF_W'(SQ_W'(ax0_q[1]) * SQ_W'(ax0_q[2]));
    ko1_d[1] = KKF_W'(SQ_W'(ax0_q[0]) * SQ_W'(ax0_q[2]));
    ko1_d[2] = KKF_W'(SQ_W'(ax0_q[0]) * SQ_W'(ax0_q[1]));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t1_q   <= ANG_Q_W'(t1_w);
      kd1_q  <= kd1_d;
      ko1_q  <= ko1_d;
      ax1_q  <= ax0_q;
      vec1_q <= vec0_q;
    end
  end

  // stage 2: mirror into +-pi/2, round k*k to the axis format
  logic signed [ANG_Q_W-1:0] t2_d, t2_q;
  logic                      flip2_d, flip2_q;
  side_t                     side2_d, side2_q;
  logic signed [KKF_W-1:0]   kd_r [3];
  logic signed [KKF_W-1:0]   ko_r [3];

  always_comb begin
    flip2_d = 1'b0;
    t2_d    = t1_q;
    if (t1_q > HALF_PI_Q30) begin
      t2_d    = PI_Q30 - t1_q;
      flip2_d = 1'b1;
    end else if (t1_q < -HALF_PI_Q30) begin
      t2_d    = -PI_Q30 - t1_q;
      flip2_d = 1'b1;
    end
    for (int n = 0; n < 3; n++) begin
      kd_r[n] = (kd1_q[n] + (KKF_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      ko_r[n] = (ko1_q[n] + (KKF_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      side2_d.kk_diag[n] = KK_W'(kd_r[n]);
      side2_d.kk_off[n]  = KK_W'(ko_r[n]);
      side2_d.axis[n]    = ax1_q[n];
    end
    side2_d.vec = vec1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      t2_q    <= t2_d;
      flip2_q <= flip2_d;
      side2_q <= side2_d;
    end
  end

  assign angle_o = t2_q;
  assign flip_o  = flip2_q;
  assign side_o  = side2_q;

endmodule

FILE: rtl/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// Rotation-mode cordic, one micro-rotation per register stage, giving the
// q30 cosine and sine of the folded angle.
// ----------------------------------------------------------------------------
module aavr_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [aavr_pkg::ANG_Q_W-1:0] angle_i,
  input  logic                                flip_i,
  input  aavr_pkg::side_t                     side_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [aavr_pkg::CW-1:0]      cos_o,
  output logic signed [aavr_pkg::CW-1:0]      sin_o,
  output logic                                flip_o,
  output aavr_pkg::side_t                     side_o
);
  import aavr_pkg::*;

  localparam int N = STEPS;

  logic [N-1:0] v_q;
  logic [N:0]   en;

  logic signed [CW-1:0]      x_q [N];
  logic signed [CW-1:0]      y_q [N];
  logic signed [ANG_Q_W-1:0] z_q [N];
  logic                      f_q [N];
  side_t                     s_q [N];

  // stage enables
  always_comb begin
    en[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [CW-1:0]      xi, yi;
    logic signed [ANG_Q_W-1:0] zi;
    logic                      fi;
    side_t                     si;

    if (k == 0) begin : g_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = angle_i;
      assign fi = flip_i;
      assign si = side_i;
    end else begin : g_next
      assign xi = x_q[k-1];
      assign yi = y_q[k-1];
      assign zi = z_q[k-1];
      assign fi = f_q[k-1];
      assign si = s_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        if (!zi[ANG_Q_W-1]) begin
          x_q[k] <= xi - (yi >>> k);
          y_q[k] <= yi + (xi >>> k);
          z_q[k] <= zi - ATAN_Q30[k];
        end else begin
          x_q[k] <= xi + (yi >>> k);
          y_q[k] <= yi - (xi >>> k);
          z_q[k] <= zi + ATAN_Q30[k];
        end
        f_q[k] <= fi;
        s_q[k] <= si;
      end
    end
  end

  assign cos_o  = x_q[N-1];
  assign sin_o  = y_q[N-1];
  assign flip_o = f_q[N-1];
  assign side_o = s_q[N-1];

endmodule

FILE: rtl/aavr_matrix.sv
// ----------------------------------------------------------------------------
// aavr_matrix
// Builds the rotation matrix from sine, cosine and the axis terms, applies it
// to the vector, rounds and saturates. Six stages, the last is the output
// register.
// ----------------------------------------------------------------------------
module aavr_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [aavr_pkg::CW-1:0]     cos_i,
  input  logic signed [aavr_pkg::CW-1:0]     sin_i,
  input  logic                               flip_i,
  input  aavr_pkg::side_t                    side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [2:0][aavr_pkg::VEC_W-1:0]    rot_o
);
  import aavr_pkg::*;

  localparam int N     = 6;
  localparam int OMC_W = CW + 2;
  localparam int K_W   = AXIS_W + 1;
  localparam int SK_W  = CW + K_W;
  localparam int OK_W  = OMC_W + KK_W;
  localparam int MW    = 34;
  localparam int PV_W  = MW + VEC_W;
  localparam int AW    = PV_W + 2;
  localparam int RW    = AW - 28;

  logic [N-1:0] v_q;
  logic [N:0]   en;

  always_comb begin
    en[N] = ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: signed cosine and one minus cosine
  logic signed [CW:0]      c0;
  logic signed [OMC_W-1:0] omc0_q;
  logic signed [CW-1:0]    s0_q;
  side_t                   side0_q;

  assign c0 = flip_i ? -(CW+1)'(cos_i) : (CW+1)'(cos_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      omc0_q  <= (OMC_W'(1) <<< 30) - OMC_W'(c0);
      s0_q    <= sin_i;
      side0_q <= side_i;
    end
  end

  // stage 1: sine times k and one minus cosine times k*k
  logic signed [K_W-1:0]    ax [3];
  logic signed [K_W-1:0]    km [3][3];
  logic signed [KK_W-1:0]   kkm [3][3];
  logic signed [SK_W-1:0]   sk1_q [3][3];
  logic signed [OK_W-1:0]   ok1_q [3][3];
  logic [2:0][VEC_W-1:0]    vec1_q;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      ax[n]     = K_W'(signed'(side0_q.axis[n]));
      km[n][n]  = '0;
      kkm[n][n] = signed'(side0_q.kk_diag[n]);
    end
    km[0][1] = -ax[2];
    km[0][2] = ax[1];
    km[1][0] = ax[2];
    km[1][2] = -ax[0];
    km[2][0] = -ax[1];
    km[2][1] = ax[0];
    kkm[0][1] = signed'(side0_q.kk_off[2]);
    kkm[1][0] = signed'(side0_q.kk_off[2]);
    kkm[0][2] = signed'(side0_q.kk_off[1]);
    kkm[2][0] = signed'(side0_q.kk_off[1]);
    kkm[1][2] = signed'(side0_q.kk_off[0]);
    kkm[2][1] = signed'(side0_q.kk_off[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sk1_q[i][j] <= SK_W'(s0_q) * SK_W'(km[i][j]);
          ok1_q[i][j] <= OK_W'(omc0_q) * OK_W'(kkm[i][j]);
        end
      end
      vec1_q <= side0_q.vec;
    end
  end

  // stage 2: matrix entries in q28
  logic signed [SK_W-1:0] skr [3][3];
  logic signed [OK_W-1:0] okr [3][3];
  logic signed [MW-1:0]   m2_d [3][3];
  logic signed [MW-1:0]   m2_q [3][3];
  logic [2:0][VEC_W-1:0]  vec2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        skr[i][j]  = (sk1_q[i][j] + (SK_W'(1) <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
        okr[i][j]  = (ok1_q[i][j] + (OK_W'(1) <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
        m2_d[i][j] = MW'(skr[i][j]) + MW'(okr[i][j]);
      end
      m2_d[i][i] = m2_d[i][i] + (MW'(1) <<< 28);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      m2_q   <= m2_d;
      vec2_q <= vec1_q;
    end
  end

  // stage 3: matrix times vector, one product per entry
  logic signed [PV_W-1:0] p3_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p3_q[i][j] <= PV_W'(m2_q[i][j]) * PV_W'(signed'(vec2_q[j]));
        end
      end
    end
  end

  // stage 4: row sums, rounded back to the vector format
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] accr [3];
  logic signed [RW-1:0] r4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = AW'(p3_q[i][0]) + AW'(p3_q[i][1]) + AW'(p3_q[i][2]);
      accr[i] = (acc[i] + (AW'(1) <<< 27)) >>> 28;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        r4_q[i] <= RW'(accr[i]);
      end
    end
  end

  // stage 5: saturate into the output register
  localparam logic signed [RW-1:0] MAX_R = RW'(33'sh0_7FFF_FFFF);
  localparam logic signed [RW-1:0] MIN_R = -MAX_R - RW'(1);

  logic [2:0][VEC_W-1:0] rot5_d, rot5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (r4_q[i] > MAX_R) begin
        rot5_d[i] = VEC_W'(MAX_R);
      end else if (r4_q[i] < MIN_R) begin
        rot5_d[i] = VEC_W'(MIN_R);
      end else begin
        rot5_d[i] = VEC_W'(r4_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      rot5_q <= rot5_d;
    end
  end

  assign rot_o = rot5_q;

endmodule

FILE: rtl/axis_angle_vector_rotation_core.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_core
// Rotates a vector about a unit axis by an angle with Rodrigues' formula:
// angle folding, a pipelined cordic for sine and cosine, then matrix build,
// matrix-vector product, rounding and saturation.
//
//   channel  dir  payload                                          handshake
//   in_i     in   vec_x/y/z, turn_angle, axis_x/y/z               valid/ready
//   out_o    out  rot_x/y/z                                       valid/ready
//
// one transaction per cycle in and out while out_o does not stall: 3 folding stages,
// 24 cordic stages (one micro-rotation each), 6 matrix stages
// every stage has its own valid bit and moves when empty or when its
// successor moves, so bubbles close up and a stall at out_o stops only the
// occupied tail of the pipeline
// reset clears the valid bits only; no clearing pass
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aavr_in_if.sink     in_i,
  aavr_out_if.source  out_o
);
  import aavr_pkg::*;

  logic                      f_valid, f_ready;
  logic signed [ANG_Q_W-1:0] f_angle;
  logic                      f_flip;
  side_t                     f_side;

  logic                      c_valid, c_ready;
  logic signed [CW-1:0]      c_cos, c_sin;
  logic                      c_flip;
  side_t                     c_side;

  logic [2:0][VEC_W-1:0]     rot;

  // angle folding and axis terms
  aavr_fold #(.FRAC_BITS(FRAC_BITS)) u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .vec_x_i      (in_i.vec_x),
    .vec_y_i      (in_i.vec_y),
    .vec_z_i      (in_i.vec_z),
    .turn_angle_i (in_i.turn_angle),
    .axis_x_i     (in_i.axis_x),
    .axis_y_i     (in_i.axis_y),
    .axis_z_i     (in_i.axis_z),
    .valid_o      (f_valid),
    .ready_i      (f_ready),
    .angle_o      (f_angle),
    .flip_o       (f_flip),
    .side_o       (f_side)
  );

  // sine and cosine
  aavr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .angle_i (f_angle),
    .flip_i  (f_flip),
    .side_i  (f_side),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .cos_o   (c_cos),
    .sin_o   (c_sin),
    .flip_o  (c_flip),
    .side_o  (c_side)
  );

  // matrix and product
  aavr_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .cos_i   (c_cos),
    .sin_i   (c_sin),
    .flip_i  (c_flip),
    .side_i  (c_side),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rot_o   (rot)
  );

  assign out_o.rot_x = signed'(rot[0]);
  assign out_o.rot_y = signed'(rot[1]);
  assign out_o.rot_z = signed'(rot[2]);

`ifndef SYNTHESIS
  // the input side only blocks when the whole pipeline is held by the output
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input blocked without an output stall");

  // nothing can come out in the first cycle after reset
  a_reset_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_o.valid)
    else $error("result present straight after reset");

  // a downstream stage never drains while the cordic tail is stalled
  a_cordic_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid && !c_ready) |-> (out_o.valid && !out_o.ready))
    else $error("cordic held while the output is free");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams vector, angle and axis transactions into the rotation core with
// bursty input and a stalling output, and compares every rotated vector with
// a fixed-point Rodrigues predictor built on a 24-step cordic.
// ----------------------------------------------------------------------------
module tb;
  import aavr_pkg::*;

  localparam int FB        = 16;
  localparam int N_RANDOM  = 1030;
  localparam int LIMIT     = 400000;

  typedef struct packed {
    logic signed [VEC_W-1:0]  vx, vy, vz;
    logic signed [ANG_W-1:0]  ang;
    logic signed [AXIS_W-1:0] ax, ay, az;
  } rot_req_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] rx, ry, rz;
  } rot_vec_t;

  localparam longint ATAN_TBL [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aavr_in_if  in_ch ();
  aavr_out_if out_ch ();

  axis_angle_vector_rotation_core #(.FRAC_BITS(FB)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // clock
  always #5 clk_i = ~clk_i;

  rot_req_t pending_q[$];
  rot_vec_t rotated_q[$];
  int       n_mismatch = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       cycles = 0;
  bit       stim_done = 1'b0;
  bit       took = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // rodrigues rotation with cordic sine and cosine, bit exact
  function automatic rot_vec_t rotate_vector(rot_req_t r);
    longint v[3], a[3], m[3][3], res[3];
    longint t, x, y, z, dx, dy, c, s, omc, kij, kk, acc;
    bit flip;
    rot_vec_t o;
    flip = 1'b0;
    v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
    a[0] = clip(r.ax, -(1 << FB), 1 << FB);
    a[1] = clip(r.ay, -(1 << FB), 1 << FB);
    a[2] = clip(r.az, -(1 << FB), 1 << FB);
    t = longint'(r.ang) * (longint'(1) <<< (30 - FB));
    t = clip(t, -longint'(TWO_PI_Q30), longint'(TWO_PI_Q30));
    if (t > longint'(PI_Q30)) t -= longint'(TWO_PI_Q30);
    else if (t < -longint'(PI_Q30)) t += longint'(TWO_PI_Q30);
    if (t > longint'(HALF_PI_Q30)) begin
      t = longint'(PI_Q30) - t;
      flip = 1'b1;
    end else if (t < -longint'(HALF_PI_Q30)) begin
      t = -longint'(PI_Q30) - t;
      flip = 1'b1;
    end
    x = longint'(GAIN_Q30);
    y = 0;
    z = t;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    c = flip ? -x : x;
    s = y;
    omc = (longint'(1) <<< 30) - c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == j) begin
          kij = 0;
          kk = -(a[(i+1)%3] * a[(i+1)%3] + a[(i+2)%3] * a[(i+2)%3]);
        end else begin
          kij = ((j - i + 3) % 3 == 1) ? -a[3-i-j] : a[3-i-j];
          kk = a[i] * a[j];
        end
        m[i][j] = (i == j ? (longint'(1) <<< 28) : 0) + round_shr(s * kij, FB + 2)
                + round_shr(omc * round_shr(kk, FB), FB + 2);
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      res[i] = clip(round_shr(acc, 28), -(longint'(1) <<< 31), 2147483647);
    end
    o.rx = res[0]; o.ry = res[1]; o.rz = res[2];
    return o;
  endfunction

  function automatic logic [31:0] rand_vec_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? $urandom_range(0, 400000)
                                     : -$urandom_range(0, 400000);
      default: return $urandom;
    endcase
  endfunction

  // a unit-ish axis along a random direction, sometimes off unit or raw
  function automatic rot_req_t rand_request();
    rot_req_t r;
    real ux, uy, uz, nrm;
    r.vx = rand_vec_coord();
    r.vy = rand_vec_coord();
    r.vz = rand_vec_coord();
    case ($urandom_range(0, 4))
      0: r.ang = $urandom;
      1: r.ang = $urandom_range(0, 1) ? 20'sd411775 : -20'sd411775;
      default: r.ang = $signed($urandom_range(0, 823550)) - 411775;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      r.ax = $urandom; r.ay = $urandom; r.az = $urandom;
    end else begin
      ux = real'($urandom_range(0, 2000)) - 1000.0;
      uy = real'($urandom_range(0, 2000)) - 1000.0;
      uz = real'($urandom_range(0, 2000)) - 1000.0;
      nrm = $sqrt(ux*ux + uy*uy + uz*uz);
      if (nrm < 1.0) begin
        ux = 1.0; nrm = 1.0;
      end
      r.ax = $rtoi(ux / nrm * 65536.0);
      r.ay = $rtoi(uy / nrm * 65536.0);
      r.az = $rtoi(uz / nrm * 65536.0);
    end
    return r;
  endfunction

  function automatic rot_req_t mk(longint vx, longint vy, longint vz, longint ang,
                                  longint ax, longint ay, longint az);
    rot_req_t r;
    r.vx = vx; r.vy = vy; r.vz = vz; r.ang = ang;
    r.ax = ax; r.ay = ay; r.az = az;
    return r;
  endfunction

  // stimulus: directed corners then random transactions
  initial begin
    pending_q.push_back(mk(65536, 0, 0, 0, 0, 0, 65536));
    pending_q.push_back(mk(65536, 0, 0, 102944, 0, 0, 65536));
    pending_q.push_back(mk(0, 65536, 0, -102944, 65536, 0, 0));
    pending_q.push_back(mk(0, 0, 65536, 205887, 0, 65536, 0));
    pending_q.push_back(mk(0, 0, 65536, -205887, 0, 65536, 0));
    pending_q.push_back(mk(12345, -6789, 1000, 411775, 37837, 37837, 37837));
    pending_q.push_back(mk(12345, -6789, 1000, -411775, 37837, -37837, 37837));
    pending_q.push_back(mk(65536, 65536, 65536, 20'sh7ffff, 0, 0, 65536));
    pending_q.push_back(mk(65536, 65536, 65536, -20'sh80000, 0, 0, 65536));
    pending_q.push_back(mk(65536, 0, 0, 300000, 0, 0, 65536));
    pending_q.push_back(mk(65536, 0, 0, -300000, 0, 0, 65536));
    pending_q.push_back(mk(65536, 0, 0, 150000, 0, 0, 65536));
    pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 50000,
                           65536, 65536, 65536));
    pending_q.push_back(mk(-32'sh80000000, -32'sh80000000, -32'sh80000000, -50000,
                           65536, 65536, 65536));
    pending_q.push_back(mk(32'h7fffffff, 0, -32'sh80000000, 205887,
                           18'sh1ffff, -18'sh20000, 18'sh1ffff));
    pending_q.push_back(mk(100000, 200000, 300000, 80000, 10000, 20000, 5000));
    pending_q.push_back(mk(-1, -1, -1, 1, 65536, 0, 0));
    pending_q.push_back(mk(0, 0, 0, 12345, 0, 65536, 0));
    pending_q.push_back(mk(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 20'h55555,
                           18'h2aaaa, 18'h15555, 18'h3ffff));
    pending_q.push_back(mk(32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0, 20'haaaaa,
                           18'h15555, 18'h2aaaa, 18'h00001));
    for (int k = 0; k < N_RANDOM; k++) pending_q.push_back(rand_request());
  end

  // input side: record each accepted transaction and its prediction
  always @(posedge clk_i) begin
    took = rst_ni && in_ch.valid && in_ch.ready;
    if (took) begin
      rotated_q.push_back(rotate_vector(pending_q.pop_front()));
      n_sent++;
    end
  end

  // driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          {in_ch.vec_x, in_ch.vec_y, in_ch.vec_z, in_ch.turn_angle,
           in_ch.axis_x, in_ch.axis_y, in_ch.axis_z} <= pending_q[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // receiver stall pattern: phases of always ready, random, mostly stalled
  int stall_mode = 0;
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // monitor: compare every output transaction with the oldest prediction
  rot_vec_t got, want;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.rx = out_ch.rot_x; got.ry = out_ch.rot_y; got.rz = out_ch.rot_z;
      if (rotated_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected transaction %h", got);
      end else begin
        want = rotated_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     n_checked, want.rx, want.ry, want.rz, got.rx, got.ry, got.rz);
        end
      end
    end
  end

  // reset, end of run and timeout
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.vec_x, in_ch.vec_y, in_ch.vec_z, in_ch.turn_angle,
     in_ch.axis_x, in_ch.axis_y, in_ch.axis_z} = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (!(stim_done && rotated_q.size() == 0) && cycles < LIMIT) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
    end else begin
      $display("covered %0d rotations (%0d checked), angle folding, axis and output",
               n_sent, n_checked);
      $display("saturation, with bursty input and output stalls; %0d mismatches",
               n_mismatch);
      if (n_mismatch == 0 && rotated_q.size() == 0) $display("tb passed");
      else $display("tb failed");
    end
    $finish;
  end

endmodule
